@@ src/icmp_erb_pkg.sv @@
// ----------------------------------------------------------------------------
// icmp_erb_pkg
// Shared operation codes, IPv4/ICMP offsets and one's-complement helper for
// the ICMP echo reply builder.
// ----------------------------------------------------------------------------
package icmp_erb_pkg;

  typedef enum logic {
    OP_PUSH = 1'b0,
    OP_READ = 1'b1
  } op_t;

  localparam int unsigned MAX_PACKET_BYTES = 2048;

  localparam int unsigned IP_HDR_BYTES   = 20;
  localparam int unsigned MIN_ECHO_BYTES = 24;
  localparam int unsigned OFS_PROTO      = 9;
  localparam int unsigned OFS_HCK_HI     = 10;
  localparam int unsigned OFS_HCK_LO     = 11;
  localparam int unsigned OFS_SRC        = 12;
  localparam int unsigned OFS_DST        = 16;
  localparam int unsigned OFS_ICMP_TYPE  = 20;
  localparam int unsigned OFS_ICMP_CK_HI = 22;
  localparam int unsigned OFS_ICMP_CK_LO = 23;
  localparam int unsigned ADDR_SWAP      = 4;

  localparam logic [7:0]  PROTO_ICMP      = 8'h01;
  localparam logic [7:0]  ICMP_ECHO_REQ   = 8'h08;
  localparam logic [7:0]  ICMP_ECHO_REPLY = 8'h00;
  localparam logic [15:0] WORD_MASK       = 16'hFFFF;

  typedef struct packed {
    logic        reply_ready;
    logic [11:0] reply_length;
    logic        overflow;
  } status_t;

  function automatic logic [15:0] ones_add(input logic [15:0] acc,
                                           input logic [15:0] word);
    logic [16:0] s;
    s = {1'b0, acc} + {1'b0, word};
    ones_add = s[15:0] + {15'd0, s[16]};
  endfunction

endpackage

@@ src/icmp_echo_reply_builder.sv @@
// ----------------------------------------------------------------------------
// icmp_echo_reply_builder
// Loads an IPv4 packet byte by byte and serves bytes of its ICMP echo reply.
// ----------------------------------------------------------------------------
// Input channel (in_valid / in_stall): each transaction is either a push of
// one packet byte (in_operation = push, in_data_byte, in_last) or a read of
// one reply byte (in_operation = read, in_read_index).
// Output channel (out_valid / out_stall): exactly one transaction per input
// transaction, in order, carrying the status after that step (reply_ready,
// reply_length, overflow) and, for a read, the reply byte.
// From input acceptance to out_valid, a transaction passes the registered read of
// the packet store RAM (with the internal stage), then the output register.
// Throughput is one transaction per cycle while in_stall is low; checksums are
// accumulated on the fly as bytes are pushed, so the only memory access per item
// is at most a single write (push) or a single read (read).
// Reset (rst_n low, synchronous) clears counters, sums and status; the packet
// store is not cleared and needs no clearing pass.
// When the receiver stalls, the output register holds, the internal stage
// fills, and in_stall rises until the output drains.
// ----------------------------------------------------------------------------
module icmp_echo_reply_builder (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_operation,
  input  logic [7:0]  in_data_byte,
  input  logic        in_last,
  input  logic [10:0] in_read_index,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_reply_ready,
  output logic [11:0] out_reply_length,
  output logic        out_overflow,
  output logic [7:0]  out_reply_byte
);

  localparam int AW = $clog2(icmp_erb_pkg::MAX_PACKET_BYTES);
  localparam int CW = $clog2(icmp_erb_pkg::MAX_PACKET_BYTES + 1);

  logic [CW-1:0] count_r, count_nxt;
  logic [15:0]   hsum_r, hsum_nxt;
  logic [15:0]   isum_r, isum_nxt;
  logic [CW-1:0] len_r, len_nxt;
  logic          valid_r, valid_nxt;
  logic          ovf_r, ovf_nxt;
  logic [7:0]    proto_r, proto_nxt;
  logic [7:0]    itype_r, itype_nxt;

  logic                 a_valid_r, a_valid_nxt;
  logic                 a_ram_r, a_ram_nxt;
  logic [7:0]           a_byte_r, a_byte_nxt;
  icmp_erb_pkg::status_t a_stat_r, a_stat_nxt;

  logic                 o_valid_r, o_valid_nxt;
  logic [7:0]           o_byte_r, o_byte_nxt;
  icmp_erb_pkg::status_t o_stat_r, o_stat_nxt;

  logic          accept;
  logic          o_free;
  logic          a_move;
  logic          wr_en;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic [7:0]    rd_data;
  logic [10:0]   map_idx;
  logic [15:0]   hck;
  logic [15:0]   ick;
  logic [15:0]   word;
  logic [31:0]   pos;
  logic [31:0]   ridx;
  logic          start;
  logic          is_push;

  assign o_free   = !o_valid_r || !out_stall;
  assign a_move   = a_valid_r && o_free;
  assign in_stall = a_valid_r && !o_free;
  assign accept   = in_valid && !in_stall;
  assign is_push  = (in_operation == icmp_erb_pkg::OP_PUSH);

  assign pos  = 32'(count_r);
  assign ridx = 32'(in_read_index);
  assign hck  = ~hsum_r & icmp_erb_pkg::WORD_MASK;
  assign ick  = ~isum_r & icmp_erb_pkg::WORD_MASK;
  assign word = pos[0] ? {8'd0, in_data_byte} : {in_data_byte, 8'd0};

  assign wr_en = accept && is_push && (pos < 32'(icmp_erb_pkg::MAX_PACKET_BYTES));
  assign rd_en = accept && !is_push;

  always_comb begin
    map_idx = in_read_index;
    if (ridx >= icmp_erb_pkg::OFS_SRC && ridx < icmp_erb_pkg::OFS_DST) begin
      map_idx = in_read_index + 11'(icmp_erb_pkg::ADDR_SWAP);
    end else if (ridx >= icmp_erb_pkg::OFS_DST && ridx < icmp_erb_pkg::IP_HDR_BYTES) begin
      map_idx = in_read_index - 11'(icmp_erb_pkg::ADDR_SWAP);
    end
  end

  assign rd_addr = AW'(map_idx);

  icmp_erb_ram #(
    .WIDTH(8),
    .DEPTH(icmp_erb_pkg::MAX_PACKET_BYTES)
  ) u_store (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(count_r[AW-1:0]),
    .wr_data(in_data_byte),
    .rd_en  (rd_en),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  always_comb begin
    count_nxt   = count_r;
    hsum_nxt    = hsum_r;
    isum_nxt    = isum_r;
    len_nxt     = len_r;
    valid_nxt   = valid_r;
    ovf_nxt     = ovf_r;
    proto_nxt   = proto_r;
    itype_nxt   = itype_r;
    start       = (count_r == '0);
    a_valid_nxt = a_valid_r;
    a_ram_nxt   = a_ram_r;
    a_byte_nxt  = a_byte_r;
    a_stat_nxt  = a_stat_r;

    if (a_move) begin
      a_valid_nxt = 1'b0;
    end

    if (accept) begin
      a_valid_nxt = 1'b1;
      a_ram_nxt   = 1'b0;
      a_byte_nxt  = 8'd0;
      if (is_push) begin
        if (start) begin
          hsum_nxt  = '0;
          isum_nxt  = '0;
          valid_nxt = 1'b0;
          len_nxt   = '0;
          ovf_nxt   = 1'b0;
        end
        if (pos < 32'(icmp_erb_pkg::MAX_PACKET_BYTES)) begin
          if (pos < icmp_erb_pkg::IP_HDR_BYTES) begin
            if (pos != icmp_erb_pkg::OFS_HCK_HI && pos != icmp_erb_pkg::OFS_HCK_LO) begin
              hsum_nxt = icmp_erb_pkg::ones_add(hsum_nxt, word);
            end
          end else if (pos != icmp_erb_pkg::OFS_ICMP_TYPE &&
                       pos != icmp_erb_pkg::OFS_ICMP_CK_HI &&
                       pos != icmp_erb_pkg::OFS_ICMP_CK_LO) begin
            isum_nxt = icmp_erb_pkg::ones_add(isum_nxt, word);
          end
          if (pos == icmp_erb_pkg::OFS_PROTO) begin
            proto_nxt = in_data_byte;
          end
          if (pos == icmp_erb_pkg::OFS_ICMP_TYPE) begin
            itype_nxt = in_data_byte;
          end
          count_nxt = count_r + CW'(1);
        end else begin
          ovf_nxt = 1'b1;
        end
        if (in_last) begin
          len_nxt   = count_nxt;
          valid_nxt = !ovf_nxt &&
                      (32'(count_nxt) >= icmp_erb_pkg::MIN_ECHO_BYTES) &&
                      (proto_nxt == icmp_erb_pkg::PROTO_ICMP) &&
                      (itype_nxt == icmp_erb_pkg::ICMP_ECHO_REQ);
          count_nxt = '0;
        end
      end else if (valid_r && ridx < 32'(len_r) &&
                   ridx < 32'(icmp_erb_pkg::MAX_PACKET_BYTES)) begin
        priority if (ridx == icmp_erb_pkg::OFS_HCK_HI) begin
          a_byte_nxt = hck[15:8];
        end else if (ridx == icmp_erb_pkg::OFS_HCK_LO) begin
          a_byte_nxt = hck[7:0];
        end else if (ridx == icmp_erb_pkg::OFS_ICMP_TYPE) begin
          a_byte_nxt = icmp_erb_pkg::ICMP_ECHO_REPLY;
        end else if (ridx == icmp_erb_pkg::OFS_ICMP_CK_HI) begin
          a_byte_nxt = ick[15:8];
        end else if (ridx == icmp_erb_pkg::OFS_ICMP_CK_LO) begin
          a_byte_nxt = ick[7:0];
        end else begin
          a_ram_nxt = 1'b1;
        end
      end
      a_stat_nxt.reply_ready  = valid_nxt;
      a_stat_nxt.reply_length = 12'(len_nxt);
      a_stat_nxt.overflow     = ovf_nxt;
    end
  end

  always_comb begin
    o_valid_nxt = o_valid_r;
    o_byte_nxt  = o_byte_r;
    o_stat_nxt  = o_stat_r;
    if (o_free) begin
      o_valid_nxt = a_valid_r;
      if (a_valid_r) begin
        o_byte_nxt = a_ram_r ? rd_data : a_byte_r;
        o_stat_nxt = a_stat_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r   <= '0;
      hsum_r    <= '0;
      isum_r    <= '0;
      len_r     <= '0;
      valid_r   <= 1'b0;
      ovf_r     <= 1'b0;
      a_valid_r <= 1'b0;
      o_valid_r <= 1'b0;
    end else begin
      count_r   <= count_nxt;
      hsum_r    <= hsum_nxt;
      isum_r    <= isum_nxt;
      len_r     <= len_nxt;
      valid_r   <= valid_nxt;
      ovf_r     <= ovf_nxt;
      a_valid_r <= a_valid_nxt;
      o_valid_r <= o_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    proto_r  <= proto_nxt;
    itype_r  <= itype_nxt;
    a_ram_r  <= a_ram_nxt;
    a_byte_r <= a_byte_nxt;
    a_stat_r <= a_stat_nxt;
    o_byte_r <= o_byte_nxt;
    o_stat_r <= o_stat_nxt;
  end

  assign out_valid        = o_valid_r;
  assign out_reply_ready  = o_stat_r.reply_ready;
  assign out_reply_length = o_stat_r.reply_length;
  assign out_overflow     = o_stat_r.overflow;
  assign out_reply_byte   = o_byte_r;

endmodule

@@ src/icmp_erb_ram.sv @@
// ----------------------------------------------------------------------------
// icmp_erb_ram
// Generic simple dual-port RAM: one write port, one read port with a
// registered read that holds its data while no read is issued.
// ----------------------------------------------------------------------------
module icmp_erb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ verif/icmp_erb_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// icmp_erb_checker
// Watches both channels of the ICMP echo reply builder, predicts the status
// and reply byte for every accepted input transaction from its own copy of
// the packet store and running checksums, and compares each accepted output
// transaction against the oldest prediction in order.
// ----------------------------------------------------------------------------
module icmp_erb_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic        in_operation,
  input  logic [7:0]  in_data_byte,
  input  logic        in_last,
  input  logic [10:0] in_read_index,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic        out_reply_ready,
  input  logic [11:0] out_reply_length,
  input  logic        out_overflow,
  input  logic [7:0]  out_reply_byte,
  output int          error_count,
  output int          outstanding
);

  localparam int unsigned STORE_BYTES  = icmp_erb_pkg::MAX_PACKET_BYTES;
  localparam int          REPORT_LIMIT = 10;

  typedef struct packed {
    logic        ready;
    logic [11:0] length;
    logic        ovf;
    logic [7:0]  rbyte;
  } reply_status_t;

  reply_status_t expected_q[$];

  logic [7:0]  pkt_mem [STORE_BYTES];
  int unsigned fill_count;
  logic [15:0] hdr_sum;
  logic [15:0] icmp_sum;
  logic [11:0] echo_len;
  logic        echo_ok;
  logic        ovf_seen;

  function automatic logic [15:0] csum_add(input logic [15:0] acc, input logic [15:0] w);
    logic [16:0] s;
    s = {1'b0, acc} + {1'b0, w};
    return s[16] ? s[15:0] + 16'd1 : s[15:0];
  endfunction

  function automatic logic [7:0] echo_byte_at(input int unsigned i);
    logic [15:0] hdr_ck;
    logic [15:0] icmp_ck;
    hdr_ck  = ~hdr_sum;
    icmp_ck = ~icmp_sum;
    if (i == icmp_erb_pkg::OFS_HCK_HI) return hdr_ck[15:8];
    if (i == icmp_erb_pkg::OFS_HCK_LO) return hdr_ck[7:0];
    if (i >= icmp_erb_pkg::OFS_SRC && i < icmp_erb_pkg::OFS_DST)
      return pkt_mem[i + icmp_erb_pkg::ADDR_SWAP];
    if (i >= icmp_erb_pkg::OFS_DST && i < icmp_erb_pkg::IP_HDR_BYTES)
      return pkt_mem[i - icmp_erb_pkg::ADDR_SWAP];
    if (i == icmp_erb_pkg::OFS_ICMP_TYPE) return icmp_erb_pkg::ICMP_ECHO_REPLY;
    if (i == icmp_erb_pkg::OFS_ICMP_CK_HI) return icmp_ck[15:8];
    if (i == icmp_erb_pkg::OFS_ICMP_CK_LO) return icmp_ck[7:0];
    return pkt_mem[i];
  endfunction

  function automatic reply_status_t next_reply_status(input icmp_erb_pkg::op_t op,
                                                      input logic [7:0] b,
                                                      input logic lst,
                                                      input logic [10:0] idx);
    reply_status_t r;
    int unsigned   p;
    logic [15:0]   w;
    r.rbyte = 8'h00;
    if (op == icmp_erb_pkg::OP_PUSH) begin
      if (fill_count == 0) begin
        hdr_sum  = 16'h0000;
        icmp_sum = 16'h0000;
        echo_ok  = 1'b0;
        echo_len = 12'd0;
        ovf_seen = 1'b0;
      end
      if (fill_count < STORE_BYTES) begin
        p = fill_count;
        pkt_mem[p] = b;
        w = p[0] ? {8'h00, b} : {b, 8'h00};
        if (p < icmp_erb_pkg::IP_HDR_BYTES) begin
          if (p != icmp_erb_pkg::OFS_HCK_HI && p != icmp_erb_pkg::OFS_HCK_LO)
            hdr_sum = csum_add(hdr_sum, w);
        end else if (p != icmp_erb_pkg::OFS_ICMP_TYPE && p != icmp_erb_pkg::OFS_ICMP_CK_HI &&
                     p != icmp_erb_pkg::OFS_ICMP_CK_LO) begin
          icmp_sum = csum_add(icmp_sum, w);
        end
        fill_count = p + 1;
      end else begin
        ovf_seen = 1'b1;
      end
      if (lst) begin
        echo_len = 12'(fill_count);
        echo_ok  = !ovf_seen && fill_count >= icmp_erb_pkg::MIN_ECHO_BYTES &&
                   pkt_mem[icmp_erb_pkg::OFS_PROTO] == icmp_erb_pkg::PROTO_ICMP &&
                   pkt_mem[icmp_erb_pkg::OFS_ICMP_TYPE] == icmp_erb_pkg::ICMP_ECHO_REQ;
        fill_count = 0;
      end
    end else if (echo_ok && idx < echo_len) begin
      r.rbyte = echo_byte_at(idx);
    end
    r.ready  = echo_ok;
    r.length = echo_len;
    r.ovf    = ovf_seen;
    return r;
  endfunction

  task automatic flag_error(input string what, input reply_status_t e, input reply_status_t g);
    error_count++;
    if (error_count <= REPORT_LIMIT) begin
      $display("%0t: %s exp ready=%0d length=%0d overflow=%0d byte=%02h",
               $time, what, e.ready, e.length, e.ovf, e.rbyte);
      $display("    got ready=%0d length=%0d overflow=%0d byte=%02h",
               g.ready, g.length, g.ovf, g.rbyte);
    end
  endtask

  always @(posedge clk) begin
    reply_status_t got;
    reply_status_t want;
    reply_status_t pred;
    if (!rst_n) begin
      expected_q.delete();
      fill_count = 0;
      hdr_sum    = 16'h0000;
      icmp_sum   = 16'h0000;
      echo_len   = 12'd0;
      echo_ok    = 1'b0;
      ovf_seen   = 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        got.ready  = out_reply_ready;
        got.length = out_reply_length;
        got.ovf    = out_overflow;
        got.rbyte  = out_reply_byte;
        if (expected_q.size() == 0) begin
          flag_error("unexpected transaction", '0, got);
        end else begin
          want = expected_q.pop_front();
          if (got.ready !== want.ready || got.length !== want.length ||
              got.ovf !== want.ovf || got.rbyte !== want.rbyte) begin
            flag_error("mismatch", want, got);
          end
        end
      end
      if (in_valid && !in_stall) begin
        pred = next_reply_status(icmp_erb_pkg::op_t'(in_operation), in_data_byte,
                                 in_last, in_read_index);
        expected_q = {expected_q, pred};
      end
    end
    outstanding <= expected_q.size();
  end

endmodule

@@ verif/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives the ICMP echo reply builder with echo requests, malformed and short
// packets and reply reads, under random bursts on the input and random
// stalls on the output; the checker predicts and compares.
// ----------------------------------------------------------------------------
module testbench;

  localparam int TARGET_TXNS  = 1450;
  localparam int CYCLE_LIMIT  = 500000;
  localparam int STORE_BYTES  = icmp_erb_pkg::MAX_PACKET_BYTES;
  localparam int DRAIN_CYCLES = 8;

  logic              clk           = 1'b0;
  logic              rst_n         = 1'b0;
  logic              in_valid      = 1'b0;
  icmp_erb_pkg::op_t in_operation  = icmp_erb_pkg::OP_PUSH;
  logic [7:0]        in_data_byte  = 8'h00;
  logic              in_last       = 1'b0;
  logic [10:0]       in_read_index = 11'd0;
  logic              out_stall     = 1'b0;
  logic              in_stall;
  logic              out_valid;
  logic              out_reply_ready;
  logic [11:0]       out_reply_length;
  logic              out_overflow;
  logic [7:0]        out_reply_byte;

  int mismatches;
  int outstanding;
  int cycle_count = 0;
  int txn_count   = 0;
  int burst_left  = 0;
  int stall_mode  = 0;
  int stall_left  = 0;

  always #5 clk = ~clk;

  icmp_echo_reply_builder dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_operation     (in_operation),
    .in_data_byte     (in_data_byte),
    .in_last          (in_last),
    .in_read_index    (in_read_index),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_reply_ready  (out_reply_ready),
    .out_reply_length (out_reply_length),
    .out_overflow     (out_overflow),
    .out_reply_byte   (out_reply_byte)
  );

  icmp_erb_checker u_chk (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_operation     (in_operation),
    .in_data_byte     (in_data_byte),
    .in_last          (in_last),
    .in_read_index    (in_read_index),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_reply_ready  (out_reply_ready),
    .out_reply_length (out_reply_length),
    .out_overflow     (out_overflow),
    .out_reply_byte   (out_reply_byte),
    .error_count      (mismatches),
    .outstanding      (outstanding)
  );

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 4);
      stall_left = $urandom_range(16, 200);
    end
    stall_left = stall_left - 1;
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 3) == 0);
      2: out_stall <= $urandom_range(0, 1);
      3: out_stall <= ($urandom_range(0, 3) != 0);
      default: out_stall <= (stall_left % 8) < 5;
    endcase
  end

  task automatic drive_txn(input icmp_erb_pkg::op_t op, input logic [7:0] b, input logic lst,
                           input logic [10:0] idx);
    int gap;
    if (burst_left <= 0) begin
      gap = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 30) : $urandom_range(1, 4);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(100, 300)
                                               : $urandom_range(1, 24);
    end
    in_valid      <= 1'b1;
    in_operation  <= op;
    in_data_byte  <= b;
    in_last       <= lst;
    in_read_index <= idx;
    do @(posedge clk); while (in_stall);
    burst_left--;
    txn_count++;
  endtask

  task automatic send_read(input logic [10:0] idx);
    drive_txn(icmp_erb_pkg::OP_READ, 8'($urandom), 1'($urandom), idx);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  function automatic logic [10:0] pick_index(input int len);
    int r;
    r = $urandom_range(0, 9);
    if (r < 4) return 11'($urandom_range(0, len - 1));
    if (r < 6)
      return 11'($urandom_range(icmp_erb_pkg::OFS_HCK_HI, icmp_erb_pkg::OFS_ICMP_CK_LO));
    if (r == 6) return 11'(len + $urandom_range(0, 2));
    return 11'($urandom_range(0, STORE_BYTES - 1));
  endfunction

  task automatic send_packet(input int len, input logic [7:0] proto,
                             input logic [7:0] type_byte, input bit all_ones,
                             input bit mix_reads);
    logic [7:0] b;
    for (int i = 0; i < len; i++) begin
      b = 8'($urandom);
      if (all_ones) b = 8'hFF;
      else if ($urandom_range(0, 7) == 0) b = $urandom_range(0, 1) ? 8'hFF : 8'h00;
      if (i == icmp_erb_pkg::OFS_PROTO) b = proto;
      if (i == icmp_erb_pkg::OFS_ICMP_TYPE) b = type_byte;
      if (mix_reads && $urandom_range(0, 39) == 0) send_read(11'($urandom));
      drive_txn(icmp_erb_pkg::OP_PUSH, b, i == len - 1, 11'($urandom));
    end
  endtask

  initial begin
    int         kind;
    int         len;
    logic [7:0] bad;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    send_read(11'h7FF);
    send_packet(25, icmp_erb_pkg::PROTO_ICMP, icmp_erb_pkg::ICMP_ECHO_REQ, 1'b1, 1'b0);
    send_read(11'(icmp_erb_pkg::OFS_HCK_LO));
    send_read(11'(icmp_erb_pkg::OFS_DST));
    send_read(11'(icmp_erb_pkg::OFS_ICMP_CK_HI));
    send_read(11'd24);
    send_read(11'd25);
    wait_drained();

    while (txn_count < TARGET_TXNS) begin
      kind = $urandom_range(0, 99);
      len  = ($urandom_range(0, 9) == 0) ? $urandom_range(65, 200) : $urandom_range(24, 64);
      bad  = 8'($urandom);
      if (kind < 60) begin
        send_packet(len, icmp_erb_pkg::PROTO_ICMP, icmp_erb_pkg::ICMP_ECHO_REQ,
                    $urandom_range(0, 15) == 0, 1'b1);
      end else if (kind < 68) begin
        if (bad == icmp_erb_pkg::PROTO_ICMP) bad = ~bad;
        send_packet(len, bad, icmp_erb_pkg::ICMP_ECHO_REQ, 1'b0, 1'b1);
      end else if (kind < 76) begin
        if (bad == icmp_erb_pkg::ICMP_ECHO_REQ) bad = ~bad;
        send_packet(len, icmp_erb_pkg::PROTO_ICMP, bad, 1'b0, 1'b1);
      end else if (kind < 88) begin
        len = $urandom_range(1, icmp_erb_pkg::MIN_ECHO_BYTES - 1);
        send_packet(len, icmp_erb_pkg::PROTO_ICMP, icmp_erb_pkg::ICMP_ECHO_REQ, 1'b0, 1'b1);
      end
      repeat ($urandom_range(1, 12)) send_read(pick_index(len));
      if ($urandom_range(0, 24) == 0) wait_drained();
    end

    send_packet(30, icmp_erb_pkg::PROTO_ICMP, icmp_erb_pkg::ICMP_ECHO_REQ, 1'b0, 1'b0);
    repeat (6) send_read(pick_index(30));

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

@@ files.f @@
src/icmp_erb_pkg.sv
src/icmp_erb_ram.sv
src/icmp_echo_reply_builder.sv
verif/icmp_erb_checker.sv
verif/testbench.sv
